// ===== rtl/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition at every clock edge outside reset.
`define CHK_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error(msg);

// Check that a condition holds in the cycle after a trigger.
`define CHK_NEXT(label, trig, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (trig) |=> (cond)) \
        else $error(msg);

`endif

// ===== rtl/socma_pkg.sv =====
package socma_pkg;

    // Sizes
    localparam int WINDOW_MAX  = 10;
    localparam int RAW_W       = 16;
    localparam int SPEED_W     = 15;
    localparam int OFFSET_W    = 6;
    localparam int WIN_W       = 4;
    localparam int TDATA_W     = 16;
    localparam int CNT_W       = $clog2(WINDOW_MAX + 1);
    localparam int IDX_W       = $clog2(WINDOW_MAX);
    localparam int SUM_W       = SPEED_W + CNT_W;
    localparam int DIV_STEPS   = SPEED_W;
    localparam int DCNT_W      = $clog2(DIV_STEPS);
    localparam int PC_W        = 3;
    localparam int CFG_ADDR_W  = 2;

    localparam logic [OFFSET_W-1:0] OFFSET_CAP = OFFSET_W'(50);
    localparam logic [SPEED_W-1:0]  SPEED_SAT  = {SPEED_W{1'b1}};

    // Register indexes
    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_OFFSET = 2'd0,
        CFG_LIMIT  = 2'd1,
        CFG_WINDOW = 2'd2
    } t_cfg_idx;

    // Datapath operations
    typedef enum logic [2:0] {
        OP_NOP       = 3'd0,
        OP_ACCEPT    = 3'd1,
        OP_STORE     = 3'd2,
        OP_ACCUM     = 3'd3,
        OP_DIVINIT   = 3'd4,
        OP_DIVSTEP   = 3'd5,
        OP_EMIT_QUOT = 3'd6,
        OP_EMIT_BYP  = 3'd7
    } t_op;

    // Jump conditions
    typedef enum logic [2:0] {
        J_NEXT     = 3'd0,
        J_ALWAYS   = 3'd1,
        J_BYPASS   = 3'd2,
        J_ACC_MORE = 3'd3,
        J_DIV_MORE = 3'd4
    } t_jump;

    // Program step addresses
    localparam logic [PC_W-1:0] PC_ACCEPT    = 3'd0;
    localparam logic [PC_W-1:0] PC_MODE      = 3'd1;
    localparam logic [PC_W-1:0] PC_STORE     = 3'd2;
    localparam logic [PC_W-1:0] PC_ACCUM     = 3'd3;
    localparam logic [PC_W-1:0] PC_DIVINIT   = 3'd4;
    localparam logic [PC_W-1:0] PC_DIVSTEP   = 3'd5;
    localparam logic [PC_W-1:0] PC_EMIT_QUOT = 3'd6;
    localparam logic [PC_W-1:0] PC_EMIT_BYP  = 3'd7;

    typedef struct packed {
        t_op              op;
        t_jump            jump;
        logic [PC_W-1:0]  target;
        logic             wait_in;
        logic             wait_out;
    } t_ucode;

    typedef struct packed {
        logic in_valid;
        logic out_busy;
        logic bypass;
        logic acc_more;
        logic div_more;
    } t_flags;

    typedef struct packed {
        logic [OFFSET_W-1:0] offset;
        logic [SPEED_W-1:0]  limit;
        logic [WIN_W-1:0]    window;
    } t_cfg;

    typedef struct packed {
        logic [CNT_W-1:0] fill;
        logic [IDX_W-1:0] slot;
    } t_stat;

endpackage

// ===== rtl/socma_sequencer.sv =====
module socma_sequencer import socma_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_flags i_flags,
    output t_op    o_op,
    output logic   o_in_ready
);

    logic [PC_W-1:0] r_pc;
    logic [PC_W-1:0] n_pc;
    t_ucode          w_word;
    logic            w_stall;
    logic            w_take;

    // Control store: one word per program step
    function automatic t_ucode ucode_rom(input logic [PC_W-1:0] pc);
        t_ucode w;
        w = '{op: OP_NOP, jump: J_ALWAYS, target: PC_ACCEPT, wait_in: 1'b0, wait_out: 1'b0};
        case (pc)
            PC_ACCEPT:    w = '{OP_ACCEPT,    J_NEXT,     PC_ACCEPT,    1'b1, 1'b0};
            PC_MODE:      w = '{OP_NOP,       J_BYPASS,   PC_EMIT_BYP,  1'b0, 1'b0};
            PC_STORE:     w = '{OP_STORE,     J_NEXT,     PC_ACCEPT,    1'b0, 1'b0};
            PC_ACCUM:     w = '{OP_ACCUM,     J_ACC_MORE, PC_ACCUM,     1'b0, 1'b0};
            PC_DIVINIT:   w = '{OP_DIVINIT,   J_NEXT,     PC_ACCEPT,    1'b0, 1'b0};
            PC_DIVSTEP:   w = '{OP_DIVSTEP,   J_DIV_MORE, PC_DIVSTEP,   1'b0, 1'b0};
            PC_EMIT_QUOT: w = '{OP_EMIT_QUOT, J_ALWAYS,   PC_ACCEPT,    1'b0, 1'b1};
            PC_EMIT_BYP:  w = '{OP_EMIT_BYP,  J_ALWAYS,   PC_ACCEPT,    1'b0, 1'b1};
            default:      w = '{OP_NOP,       J_ALWAYS,   PC_ACCEPT,    1'b0, 1'b0};
        endcase
        return w;
    endfunction

    // Fetch, evaluate jump, hold on handshake waits
    always_comb begin
        w_word  = ucode_rom(r_pc);
        w_stall = (w_word.wait_in && !i_flags.in_valid) ||
                  (w_word.wait_out && i_flags.out_busy);
        case (w_word.jump)
            J_NEXT:     w_take = 1'b0;
            J_ALWAYS:   w_take = 1'b1;
            J_BYPASS:   w_take = i_flags.bypass;
            J_ACC_MORE: w_take = i_flags.acc_more;
            J_DIV_MORE: w_take = i_flags.div_more;
            default:    w_take = 1'b0;
        endcase
        if (w_stall) begin
            n_pc = r_pc;
        end else if (w_take) begin
            n_pc = w_word.target;
        end else begin
            n_pc = r_pc + PC_W'(1);
        end
        o_op       = w_stall ? OP_NOP : w_word.op;
        // Hold ready low while in reset
        o_in_ready = i_rst_n && (w_word.op == OP_ACCEPT);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= PC_ACCEPT;
        end else begin
            r_pc <= n_pc;
        end
    end

endmodule

// ===== rtl/socma_datapath.sv =====
module socma_datapath import socma_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_op                i_op,
    input  t_cfg               i_cfg,
    input  logic [RAW_W-1:0]   i_raw_speed,
    input  logic               i_in_valid,
    input  logic               i_out_ready,
    output t_flags             o_flags,
    output t_stat              o_stat,
    output logic               o_out_valid,
    output logic [SPEED_W-1:0] o_avg_speed
);

    logic [SPEED_W-1:0] r_ring [WINDOW_MAX];
    logic [IDX_W-1:0]   r_slot;
    logic [CNT_W-1:0]   r_fill;
    logic               r_out_valid;
    logic [SPEED_W-1:0] r_out_data;
    logic [SPEED_W-1:0] r_sample;
    logic [SUM_W-1:0]   r_sum;
    logic [IDX_W-1:0]   r_idx;
    logic [CNT_W-1:0]   r_rem;
    logic [SPEED_W-1:0] r_quot;
    logic [DCNT_W-1:0]  r_dcnt;

    logic [RAW_W-1:0]   w_diff;
    logic [SPEED_W-1:0] w_sat;
    logic [SPEED_W-1:0] w_cond;
    logic [CNT_W-1:0]   w_win;
    logic [CNT_W-1:0]   w_slot_inc;
    logic [CNT_W:0]     w_fill_inc;
    logic [CNT_W:0]     w_trial;
    logic               w_qbit;
    logic [CNT_W-1:0]   w_rem_next;

    // Offset, floor at zero, saturate, clamp
    always_comb begin
        w_diff = (i_raw_speed > RAW_W'(i_cfg.offset)) ?
                 (i_raw_speed - RAW_W'(i_cfg.offset)) : '0;
        w_sat  = (w_diff > RAW_W'(SPEED_SAT)) ? SPEED_SAT : w_diff[SPEED_W-1:0];
        w_cond = ((i_cfg.limit != '0) && (w_sat > i_cfg.limit)) ? i_cfg.limit : w_sat;
    end

    // Effective window, ring pointer and fill count updates
    always_comb begin
        w_win      = (32'(i_cfg.window) > WINDOW_MAX) ? CNT_W'(WINDOW_MAX)
                                                      : CNT_W'(i_cfg.window);
        w_slot_inc = CNT_W'(r_slot) + CNT_W'(1);
        w_fill_inc = {1'b0, r_fill} + (CNT_W+1)'(1);
    end

    // Restoring divide step: remainder stays below the divisor
    always_comb begin
        w_trial    = {r_rem, r_quot[SPEED_W-1]};
        w_qbit     = (w_trial >= {1'b0, r_fill});
        w_rem_next = w_qbit ? CNT_W'(w_trial - {1'b0, r_fill}) : w_trial[CNT_W-1:0];
    end

    // Status for the sequencer
    always_comb begin
        o_flags.in_valid = i_in_valid;
        o_flags.out_busy = r_out_valid && !i_out_ready;
        o_flags.bypass   = (i_cfg.window <= WIN_W'(1));
        o_flags.acc_more = (({1'b0, CNT_W'(r_idx)} + (CNT_W+1)'(1)) < {1'b0, r_fill});
        o_flags.div_more = (r_dcnt != DCNT_W'(DIV_STEPS - 1));
        o_stat.fill      = r_fill;
        o_stat.slot      = r_slot;
    end

    // Ring, pointers and output word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < WINDOW_MAX; i++) begin
                r_ring[i] <= '0;
            end
            r_slot      <= '0;
            r_fill      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_op == OP_STORE) begin
                r_ring[r_slot] <= r_sample;
                r_slot <= (w_slot_inc >= w_win) ? '0 : w_slot_inc[IDX_W-1:0];
                r_fill <= (w_fill_inc >= {1'b0, w_win}) ? w_win : w_fill_inc[CNT_W-1:0];
            end
            if (i_op == OP_EMIT_QUOT || i_op == OP_EMIT_BYP) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Working registers
    always_ff @(posedge i_clk) begin
        case (i_op)
            OP_ACCEPT: begin
                r_sample <= w_cond;
            end
            OP_STORE: begin
                r_sum <= '0;
                r_idx <= '0;
            end
            OP_ACCUM: begin
                r_sum <= r_sum + SUM_W'(r_ring[r_idx]);
                r_idx <= r_idx + IDX_W'(1);
            end
            OP_DIVINIT: begin
                r_rem  <= r_sum[SUM_W-1:SPEED_W];
                r_quot <= r_sum[SPEED_W-1:0];
                r_dcnt <= '0;
            end
            OP_DIVSTEP: begin
                r_rem  <= w_rem_next;
                r_quot <= {r_quot[SPEED_W-2:0], w_qbit};
                r_dcnt <= r_dcnt + DCNT_W'(1);
            end
            OP_EMIT_QUOT: begin
                r_out_data <= r_quot;
            end
            OP_EMIT_BYP: begin
                r_out_data <= r_sample;
            end
            default: begin
            end
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_avg_speed = r_out_data;

endmodule

// ===== rtl/speed_offset_clamp_moving_average.sv =====
// Speed conditioner: each input word is a raw ground speed; the block subtracts the
// offset register (capped at 50), floors at zero, saturates to 32767, clamps to the
// limit register when it is nonzero, and then either passes the sample straight out
// (window 0 or 1) or stores it in a ring of up to 10 samples and returns the truncated
// mean of the filled entries. Exactly one output word follows every input word. A small
// microprogram runs one item at a time; averaging uses a one-entry-per-cycle summing
// walk over the filled ring entries and then the 15-step serial divide. The next input
// is taken while a finished word still waits in the output register. The ring is
// cleared by reset itself, so no clearing pass follows reset. Write configuration only
// while the block is idle.
`include "assert_macros.svh"

module speed_offset_clamp_moving_average import socma_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Configuration write port
    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [SPEED_W-1:0]    i_cfg_wdata,
    // Input stream
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [TDATA_W-1:0]    s_axis_tdata,   // [15:0] raw_speed
    // Output stream
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [TDATA_W-1:0]    m_axis_tdata    // [14:0] avg_speed, [15] zero
);

    t_cfg               r_cfg;
    t_op                w_op;
    t_flags             w_flags;
    t_stat              w_stat;
    logic [SPEED_W-1:0] w_avg_speed;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_addr))
                CFG_OFFSET: begin
                    r_cfg.offset <= (i_cfg_wdata[OFFSET_W-1:0] > OFFSET_CAP) ?
                                    OFFSET_CAP : i_cfg_wdata[OFFSET_W-1:0];
                end
                CFG_LIMIT: begin
                    r_cfg.limit <= i_cfg_wdata;
                end
                CFG_WINDOW: begin
                    r_cfg.window <= i_cfg_wdata[WIN_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    socma_sequencer u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_flags    (w_flags),
        .o_op       (w_op),
        .o_in_ready (s_axis_tready)
    );

    socma_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_op        (w_op),
        .i_cfg       (r_cfg),
        .i_raw_speed (s_axis_tdata),
        .i_in_valid  (s_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_flags     (w_flags),
        .o_stat      (w_stat),
        .o_out_valid (m_axis_tvalid),
        .o_avg_speed (w_avg_speed)
    );

    assign m_axis_tdata = {{(TDATA_W - SPEED_W){1'b0}}, w_avg_speed};

    // Checks
    `CHK_ALWAYS(a_offset_cap, r_cfg.offset <= OFFSET_CAP, "offset register above cap")
    `CHK_ALWAYS(a_fill_range, w_stat.fill <= CNT_W'(WINDOW_MAX), "fill count above window")
    `CHK_ALWAYS(a_slot_range, 32'(w_stat.slot) < WINDOW_MAX, "ring slot out of range")
    `CHK_NEXT(a_one_at_a_time, s_axis_tvalid && s_axis_tready, !s_axis_tready, "ready after accept")

endmodule

// ===== tb/tb_speed_offset_clamp_moving_average.sv =====
`timescale 1ns / 1ps

module tb_speed_offset_clamp_moving_average;
    import socma_pkg::*;

    // Register index that decodes to no register
    localparam logic [CFG_ADDR_W-1:0] CFG_UNUSED = 2'd3;

    // Tracks the block's settings and ring and holds the averages still owed
    class speed_scoreboard;
        int unsigned          offset;
        int unsigned          limit;
        int unsigned          window;
        logic [SPEED_W-1:0]   ring [WINDOW_MAX];
        int unsigned          slot;
        int unsigned          fill;
        logic [SPEED_W-1:0]   pending_avg [$];
        int                   errors;

        function new();
            offset = 0;
            limit  = 0;
            window = 0;
            foreach (ring[i]) ring[i] = '0;
            slot   = 0;
            fill   = 0;
            errors = 0;
        endfunction

        function void write_reg(logic [CFG_ADDR_W-1:0] idx, logic [SPEED_W-1:0] value);
            int unsigned v;
            case (idx)
                CFG_OFFSET: begin
                    v = 32'(value[OFFSET_W-1:0]);
                    offset = (v > 32'(OFFSET_CAP)) ? 32'(OFFSET_CAP) : v;
                end
                CFG_LIMIT:  limit = 32'(value);
                CFG_WINDOW: window = 32'(value[WIN_W-1:0]);
                default: ;
            endcase
        endfunction

        // Offset, floor at zero, saturate, then clamp to the limit
        function logic [SPEED_W-1:0] condition(logic [RAW_W-1:0] raw);
            int unsigned v;
            v = (32'(raw) <= offset) ? 0 : 32'(raw) - offset;
            if (v > 32'(SPEED_SAT)) v = 32'(SPEED_SAT);
            if (limit != 0 && v > limit) v = limit;
            return v[SPEED_W-1:0];
        endfunction

        function void note_sample(logic [RAW_W-1:0] raw);
            logic [SPEED_W-1:0] s;
            int unsigned        win;
            int unsigned        sum;
            s = condition(raw);
            if (window <= 1) begin
                pending_avg.push_back(s);
                return;
            end
            win = (window > WINDOW_MAX) ? WINDOW_MAX : window;
            if (slot >= WINDOW_MAX) slot = 0;
            ring[slot] = s;
            slot++;
            if (slot >= win) slot = 0;
            fill++;
            if (fill >= win) fill = win;
            sum = 0;
            for (int i = 0; i < fill && i < WINDOW_MAX; i++) sum += 32'(ring[i]);
            pending_avg.push_back(SPEED_W'(sum / fill));
        endfunction

        function void check_avg(logic [TDATA_W-1:0] word);
            logic [TDATA_W-1:0] want;
            if (pending_avg.size() == 0) begin
                $display("%0t: avg_speed word 0x%04h arrived with nothing expected",
                         $time, word);
                errors++;
                return;
            end
            want = {1'b0, pending_avg.pop_front()};
            if (word !== want) begin
                $display("%0t: avg_speed expected 0x%04h (%0d), got 0x%04h (%0d)",
                         $time, want, want, word, word);
                errors++;
            end
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_ADDR_W-1:0] i_cfg_addr;
    logic [SPEED_W-1:0]    i_cfg_wdata;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [TDATA_W-1:0]    s_axis_tdata;   // [15:0] raw_speed
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [TDATA_W-1:0]    m_axis_tdata;   // [14:0] avg_speed, [15] zero

    speed_scoreboard sb = new();

    speed_offset_clamp_moving_average u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Hard stop
    initial begin
        #5ms;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Receiver: stall in chunks, each following its own random 32-bit pattern
    initial begin : rx_stall
        logic [31:0] stall_bits;
        m_axis_tready = 1'b0;
        forever begin
            case ($urandom_range(0, 3))
                0:       stall_bits = '1;
                1:       stall_bits = $urandom;
                2:       stall_bits = $urandom | $urandom;
                default: stall_bits = $urandom & $urandom;
            endcase
            for (int i = 0; i < 32; i++) begin
                @(negedge i_clk);
                m_axis_tready <= stall_bits[i];
            end
        end
    end

    // Check every accepted output word
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            sb.check_avg(m_axis_tdata);
        end
    end

    // Write one register, then drop the enable
    task automatic write_reg(logic [CFG_ADDR_W-1:0] idx, logic [SPEED_W-1:0] value);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        sb.write_reg(idx, value);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Present one word and hold it until taken
    task automatic send_sample(logic [RAW_W-1:0] raw);
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= raw;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        sb.note_sample(raw);
    endtask

    task automatic idle_input(int cycles);
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= TDATA_W'($urandom);
        repeat (cycles) @(posedge i_clk);
    endtask

    // Stop sending and wait until every average owed has come out
    task automatic drain();
        idle_input(0);
        while (sb.pending_avg.size() != 0) @(posedge i_clk);
    endtask

    // Bias raw samples toward the offset, saturation and limit boundaries
    function automatic logic [RAW_W-1:0] pick_raw();
        int unsigned lim;
        lim = (sb.limit == 0) ? 1000 : sb.limit;
        case ($urandom_range(0, 7))
            0:       return RAW_W'($urandom_range(0, 100));
            1:       return RAW_W'($urandom_range(32700, 32850));
            2:       return RAW_W'($urandom_range(65500, 65535));
            3:       return RAW_W'($urandom_range(lim + 48, lim + 52));
            4:       return RAW_W'($urandom_range(0, 2000));
            default: return RAW_W'($urandom);
        endcase
    endfunction

    // Send a run of random words in bursts with gaps between them
    task automatic send_random(int count);
        int burst_left;
        burst_left = $urandom_range(1, 12);
        for (int n = 0; n < count; n++) begin
            send_sample(pick_raw());
            burst_left--;
            if (burst_left == 0) begin
                idle_input($urandom_range(0, 12));
                burst_left = ($urandom_range(0, 4) == 0) ? 40 : $urandom_range(1, 12);
            end
        end
    endtask

    function automatic logic [SPEED_W-1:0] pick_limit();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return SPEED_W'(1);
            2:       return SPEED_SAT;
            3:       return SPEED_W'($urandom_range(1, 3000));
            default: return SPEED_W'($urandom);
        endcase
    endfunction

    function automatic logic [SPEED_W-1:0] pick_offset();
        logic [SPEED_W-1:0] junk;
        junk = SPEED_W'($urandom);
        case ($urandom_range(0, 4))
            0:       return {junk[SPEED_W-1:OFFSET_W], 6'd0};
            1:       return {junk[SPEED_W-1:OFFSET_W], 6'd50};
            2:       return {junk[SPEED_W-1:OFFSET_W], 6'd63};
            default: return junk;
        endcase
    endfunction

    function automatic logic [SPEED_W-1:0] pick_window();
        logic [SPEED_W-1:0] junk;
        junk = SPEED_W'($urandom);
        case ($urandom_range(0, 5))
            0:       return {junk[SPEED_W-1:WIN_W], 4'($urandom_range(0, 1))};
            1:       return {junk[SPEED_W-1:WIN_W], 4'd10};
            2:       return {junk[SPEED_W-1:WIN_W], 4'($urandom_range(11, 15))};
            default: return {junk[SPEED_W-1:WIN_W], 4'($urandom_range(2, 10))};
        endcase
    endfunction

    // Main sequence
    initial begin
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_addr    = CFG_OFFSET;
        i_cfg_wdata   = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings: bypass, no offset, no clamp; saturation above 32767
        send_sample(16'd0);
        send_sample(16'hFFFF);
        send_sample(16'd32767);
        send_sample(16'd32768);
        send_sample(16'd1);
        drain();

        // Offset capped at 50, floor at zero, clamp at 1000
        write_reg(CFG_OFFSET, 15'h003F);
        write_reg(CFG_LIMIT, 15'd1000);
        send_sample(16'd50);
        send_sample(16'd49);
        send_sample(16'd51);
        send_sample(16'd1050);
        send_sample(16'd1051);
        send_sample(16'hFFFF);
        drain();

        // Unused index is ignored; offset takes only its low bits
        write_reg(CFG_UNUSED, 15'h7FFF);
        write_reg(CFG_OFFSET, 15'h7FC5);
        write_reg(CFG_LIMIT, SPEED_SAT);
        // Window above the ring size acts as the ring size
        write_reg(CFG_WINDOW, 15'h000F);
        send_sample(16'd1005);
        send_sample(16'd2005);
        send_sample(16'd65535);
        drain();

        // Shrink the window below the write slot, then bypass
        write_reg(CFG_WINDOW, 15'd2);
        send_sample(16'd105);
        send_sample(16'd305);
        drain();
        write_reg(CFG_WINDOW, 15'd1);
        send_sample(16'd77);
        drain();

        // Random phases with fresh settings in between
        for (int phase = 0; phase < 10; phase++) begin
            write_reg(CFG_OFFSET, pick_offset());
            write_reg(CFG_LIMIT, pick_limit());
            write_reg(CFG_WINDOW, pick_window());
            if (phase == 4) write_reg(CFG_UNUSED, SPEED_W'($urandom));
            send_random(20);
            // Hold off once mid-phase until the pipe is empty
            if (phase == 3) drain();
            send_random(20);
            drain();
        end

        // Let any stray word show up
        idle_input(60);
        if (sb.errors == 0 && sb.pending_avg.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/socma_pkg.sv
rtl/socma_sequencer.sv
rtl/socma_datapath.sv
rtl/speed_offset_clamp_moving_average.sv
tb/tb_speed_offset_clamp_moving_average.sv
